// ----- rtl/core/bdq_pkg.sv -----
package bdq_pkg;

	// storage depth
	localparam int CAPACITY = 64;

	// fixed field widths
	localparam int CMD_W   = 3;
	localparam int VAL_W   = 32;
	localparam int POS_W   = 7;
	localparam int COUNT_W = 7;
	localparam int STAT_W  = 2;

	// derived widths
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_INSERT     = 3'd2,
		CMD_POP_FRONT  = 3'd3,
		CMD_POP_BACK   = 3'd4
	} bdq_cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} bdq_status_t;

	typedef struct packed {
		logic [CMD_W-1:0]        cmd;
		logic signed [VAL_W-1:0] value;
		logic [POS_W-1:0]        position;
	} bdq_req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] first_value;
		logic signed [VAL_W-1:0] last_value;
		logic [COUNT_W-1:0]      count;
		logic                    empty_res;
		logic [STAT_W-1:0]       status;
	} bdq_res_t;

	// per-cycle update applied to the storage cells
	typedef struct packed {
		logic                    ins;
		logic                    shl;
		logic [IDX_W-1:0]        idx;
		logic signed [VAL_W-1:0] value;
	} bdq_op_t;

	// command outcome heading to the result stage
	typedef struct packed {
		logic        valid;
		bdq_status_t status;
	} bdq_stat_t;

endpackage

// ----- rtl/core/bdq_ctrl.sv -----
module bdq_ctrl import bdq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  bdq_req_t         req,
	output bdq_op_t          op,
	output logic [CNT_W-1:0] count_q,
	output bdq_stat_t        stat_s2
);

	logic             valid_s1;
	bdq_req_t         req_s1;
	logic [CNT_W-1:0] count_d;
	bdq_status_t      status_d;
	logic             full;
	logic             empty;
	logic             pos_beyond;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			req_s1 <= req;
		end
	end

	assign full       = (count_q == CNT_W'(CAPACITY));
	assign empty      = (count_q == '0);
	assign pos_beyond = (CMP_W'(req_s1.position) >= CMP_W'(count_q));

	always_comb begin
		op.ins   = 1'b0;
		op.shl   = 1'b0;
		op.idx   = '0;
		op.value = req_s1.value;
		count_d  = count_q;
		status_d = ST_DONE;
		if (valid_s1) begin
			case (req_s1.cmd)
				CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
					if (full) begin
						status_d = ST_FULL;
					end else begin
						op.ins  = 1'b1;
						count_d = count_q + 1'b1;
						if (req_s1.cmd == CMD_PUSH_FRONT) begin
							op.idx = '0;
						end else if (req_s1.cmd == CMD_PUSH_BACK || pos_beyond) begin
							op.idx = count_q[IDX_W-1:0];
						end else begin
							op.idx = IDX_W'(req_s1.position);
						end
					end
				end
				CMD_POP_FRONT: begin
					if (empty) begin
						status_d = ST_EMPTY;
					end else begin
						op.shl  = 1'b1;
						count_d = count_q - 1'b1;
					end
				end
				CMD_POP_BACK: begin
					if (empty) begin
						status_d = ST_EMPTY;
					end else begin
						count_d = count_q - 1'b1;
					end
				end
				default: begin
					status_d = ST_DONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			stat_s2.valid  <= 1'b0;
			stat_s2.status <= ST_DONE;
		end else begin
			count_q        <= count_d;
			stat_s2.valid  <= valid_s1;
			stat_s2.status <= status_d;
		end
	end

	// count stays within capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("count above capacity");

	// insert and shift never in the same cycle
	a_op_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(op.ins && op.shl))
		else $error("insert and shift together");

	// an insert grows the count by one
	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		op.ins |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not grow count");

	// dropped push only when full
	a_full_stat: assert property (@(posedge clk) disable iff (!arst_n)
		(stat_s2.valid && stat_s2.status == ST_FULL) |-> count_q == CNT_W'(CAPACITY))
		else $error("full status with room left");

	// ignored pop only when empty
	a_empty_stat: assert property (@(posedge clk) disable iff (!arst_n)
		(stat_s2.valid && stat_s2.status == ST_EMPTY) |-> count_q == '0)
		else $error("empty status with values stored");

endmodule

// ----- rtl/core/bdq_cells.sv -----
module bdq_cells import bdq_pkg::*; (
	input  logic                    clk,
	input  bdq_op_t                 op,
	input  logic [IDX_W-1:0]        last_idx,
	output logic signed [VAL_W-1:0] first_value,
	output logic signed [VAL_W-1:0] last_value
);

	logic signed [VAL_W-1:0] cells_q [CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VAL_W-1:0] from_lo;
		logic signed [VAL_W-1:0] from_hi;

		// neighbor toward the front
		if (i == 0) begin : g_lo_edge
			assign from_lo = op.value;
		end else begin : g_lo
			assign from_lo = cells_q[i-1];
		end

		// neighbor toward the back
		if (i == CAPACITY - 1) begin : g_hi_edge
			assign from_hi = cells_q[i];
		end else begin : g_hi
			assign from_hi = cells_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (op.ins) begin
				if (IDX_W'(i) == op.idx) begin
					cells_q[i] <= op.value;
				end else if (IDX_W'(i) > op.idx) begin
					cells_q[i] <= from_lo;
				end
			end else if (op.shl) begin
				cells_q[i] <= from_hi;
			end
		end
	end

	assign first_value = cells_q[0];
	assign last_value  = cells_q[last_idx];

endmodule

// ----- rtl/core/bounded_deque_with_insert_core.sv -----
// a request taken at an edge passes the input register, the cell update and the result
// register in that order, and then shows its result with done high
// throughput: one request per cycle; busy stays low, every cell shifts or holds in parallel
// the result port has no back-pressure: done lasts one cycle and the result is taken then
// reset clears the count and the pipeline valids; cell contents stay unknown until written
module bounded_deque_with_insert_core import bdq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  bdq_req_t req,
	output logic     done,
	output bdq_res_t result
);

	bdq_op_t                 op;
	logic [CNT_W-1:0]        count_q;
	bdq_stat_t               stat_s2;
	logic [CNT_W-1:0]        count_m1;
	logic [IDX_W-1:0]        last_idx;
	logic signed [VAL_W-1:0] cell_first;
	logic signed [VAL_W-1:0] cell_last;
	logic                    empty;
	bdq_res_t                result_d;
	bdq_res_t                result_q;
	logic                    done_q;

	// a request is taken every cycle, so the block never pushes back
	assign busy = 1'b0;

	// input register, command decode and the count
	bdq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req),
		.op      (op),
		.count_q (count_q),
		.stat_s2 (stat_s2)
	);

	// back of the store sits at count minus one
	assign count_m1 = count_q - 1'b1;
	assign last_idx = count_m1[IDX_W-1:0];

	// shifting storage cells, front at cell zero
	bdq_cells u_cells (
		.clk         (clk),
		.op          (op),
		.last_idx    (last_idx),
		.first_value (cell_first),
		.last_value  (cell_last)
	);

	// the cells and count already hold the state after the command,
	// so the result is read straight off them
	assign empty = (count_q == '0);

	always_comb begin
		result_d.first_value = empty ? '0 : cell_first;
		result_d.last_value  = empty ? '0 : cell_last;
		result_d.count       = COUNT_W'(count_q);
		result_d.empty_res   = empty;
		result_d.status      = stat_s2.status;
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= stat_s2.valid;
		end
	end

	// result payload, loaded only when a command finishes
	always_ff @(posedge clk) begin
		if (stat_s2.valid) begin
			result_q <= result_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ----- tb/bounded_deque_with_insert_core_tb.sv -----
module bounded_deque_with_insert_core_tb import bdq_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// cycles with neither a taken request nor a result before the run is abandoned
	localparam int WATCHDOG_LIMIT = 500;
	// settle time after the last result, a little over the three-stage latency
	localparam int TAIL_CYCLES = 8;

	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	// codes the block must treat as no-ops
	localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	logic     busy;
	bdq_req_t req = '0;
	logic     done;
	bdq_res_t result;

	// shadow copy of the stored values, front at index 0
	logic signed [VAL_W-1:0] deque_image[$];
	// snapshots the block owes us, oldest first
	bdq_res_t pending_snapshots[$];
	bdq_res_t want_snapshot;

	int error_count = 0;
	int idle_cycles = 0;
	// when clear the sender runs back to back
	bit sender_gaps_on = 1'b1;

	bounded_deque_with_insert_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.result (result)
	);

	always #4 clk = ~clk;

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("%0t mismatch on %s: got %h want %h", $realtime, field, got, want);
		error_count++;
	endtask

	// applies one request to the shadow deque and returns the snapshot it should leave
	function automatic bdq_res_t apply_deque_command(bdq_req_t r);
		bdq_res_t s;
		int n;
		n = deque_image.size();
		s = '0;
		s.status = ST_DONE;
		case (r.cmd)
			CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
				if (n >= CAPACITY) begin
					s.status = ST_FULL;
				end else if (r.cmd == CMD_PUSH_FRONT) begin
					deque_image.push_front(r.value);
				end else if (r.cmd == CMD_PUSH_BACK || int'(r.position) >= n) begin
					// an index at or past the count appends
					deque_image.push_back(r.value);
				end else begin
					deque_image.insert(int'(r.position), r.value);
				end
			end
			CMD_POP_FRONT, CMD_POP_BACK: begin
				if (n == 0) begin
					s.status = ST_EMPTY;
				end else if (r.cmd == CMD_POP_FRONT) begin
					void'(deque_image.pop_front());
				end else begin
					void'(deque_image.pop_back());
				end
			end
			default: ;
		endcase
		n = deque_image.size();
		if (n != 0) begin
			s.first_value = deque_image[0];
			s.last_value = deque_image[n-1];
		end
		s.count = n[COUNT_W-1:0];
		s.empty_res = (n == 0);
		return s;
	endfunction

	// one process sees both ends at each edge: results are checked first, then the
	// request taken at that edge is predicted, so ordering never depends on the scheduler
	always @(posedge clk) begin
		if (arst_n) begin
			if (done === 1'b1) begin
				if (pending_snapshots.size() == 0) begin
					report_mismatch("unexpected result", 32'(result.count), '0);
				end else begin
					want_snapshot = pending_snapshots.pop_front();
					if (result.first_value !== want_snapshot.first_value)
						report_mismatch("first_value", result.first_value,
							want_snapshot.first_value);
					if (result.last_value !== want_snapshot.last_value)
						report_mismatch("last_value", result.last_value,
							want_snapshot.last_value);
					if (result.count !== want_snapshot.count)
						report_mismatch("count", 32'(result.count),
							32'(want_snapshot.count));
					if (result.empty_res !== want_snapshot.empty_res)
						report_mismatch("empty_res", 32'(result.empty_res),
							32'(want_snapshot.empty_res));
					if (result.status !== want_snapshot.status)
						report_mismatch("status", 32'(result.status),
							32'(want_snapshot.status));
				end
			end
			if (start && busy === 1'b0)
				pending_snapshots.push_back(apply_deque_command(req));
		end
	end

	// watchdog: any taken request or any result counts as progress
	always @(posedge clk) begin
		if ((start && busy === 1'b0) || done === 1'b1)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired after %0d quiet cycles", idle_cycles);
			$display("[bounded_deque_with_insert_core] ERROR");
			$finish;
		end
	end

	// sends one request: optional gap, then hold start until the edge that takes it
	task automatic send_request(logic [CMD_W-1:0] cmd, logic signed [VAL_W-1:0] value,
		logic [POS_W-1:0] position);
		int gap;
		gap = sender_gaps_on ? $urandom_range(0, 7) : 0;
		@(negedge clk);
		if (gap > 0) begin
			// start drops here and only rises again after the gap
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.cmd = cmd;
		req.value = value;
		req.position = position;
		start = 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		start = 1'b0;
	endtask

	// pressure point: hold off until every owed result is back
	task automatic wait_until_drained();
		stop_sending();
		while (pending_snapshots.size() != 0) @(negedge clk);
	endtask

	// mostly full-range random, sometimes one of the corner values
	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 15))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2: return '0;
			3: return -1;
			default: return $urandom;
		endcase
	endfunction

	// half the time an index up to and including the current count, otherwise anywhere in 7 bits
	function automatic logic [POS_W-1:0] pick_position();
		if ($urandom_range(0, 1))
			return POS_W'($urandom_range(0, deque_image.size()));
		return POS_W'($urandom_range(0, 127));
	endfunction

	task automatic test_directed();
		sender_gaps_on = 1'b0;
		// empty store: pops are refused and spare codes leave it alone
		send_request(CMD_POP_FRONT, VAL_MAX, 7'd0);
		send_request(CMD_POP_BACK, VAL_MIN, 7'd127);
		send_request(CMD_SPARE_5, 32'sd5, 7'd5);
		send_request(CMD_SPARE_6, 32'sd6, 7'd6);
		send_request(CMD_SPARE_7, 32'sd7, 7'd7);
		// insert far past the count on an empty store goes to the back
		send_request(CMD_INSERT, VAL_MAX, 7'd127);
		send_request(CMD_PUSH_FRONT, VAL_MIN, 7'd0);
		send_request(CMD_PUSH_BACK, 32'sd0, 7'd0);
		sender_gaps_on = 1'b1;
		// insert at zero acts as push front, in the middle shifts the tail
		send_request(CMD_INSERT, -32'sd1, 7'd0);
		send_request(CMD_INSERT, 32'sd1, 7'd1);
		// index equal to the count and beyond it both append
		send_request(CMD_INSERT, 32'sh5555_5555, 7'd5);
		send_request(CMD_INSERT, 32'shAAAA_AAAA, 7'd64);
		send_request(CMD_INSERT, 32'sh1234_5678, 7'd3);
		send_request(CMD_SPARE_7, VAL_MAX, 7'd127);
		send_request(CMD_POP_FRONT, 32'sd0, 7'd0);
		send_request(CMD_POP_BACK, 32'sd0, 7'd0);
		send_request(CMD_POP_FRONT, 32'sd0, 7'd0);
		send_request(CMD_POP_BACK, 32'sd0, 7'd0);
		send_request(CMD_POP_FRONT, 32'sd0, 7'd0);
		send_request(CMD_POP_BACK, 32'sd0, 7'd0);
		send_request(CMD_POP_FRONT, 32'sd0, 7'd0);
		send_request(CMD_POP_BACK, 32'sd0, 7'd0);
		wait_until_drained();
	endtask

	task automatic test_full_store();
		// fill back to back so the cells are updated on consecutive cycles
		sender_gaps_on = 1'b0;
		while (deque_image.size() < CAPACITY)
			send_request(CMD_W'($urandom_range(CMD_PUSH_FRONT, CMD_INSERT)), pick_value(),
				pick_position());
		// every kind of push into a full store is dropped, but after the pop one insert fits
		sender_gaps_on = 1'b1;
		send_request(CMD_PUSH_FRONT, VAL_MAX, 7'd0);
		send_request(CMD_PUSH_BACK, VAL_MIN, 7'd0);
		send_request(CMD_INSERT, 32'sd9, 7'd32);
		send_request(CMD_INSERT, 32'sd10, 7'd127);
		send_request(CMD_POP_BACK, 32'sd0, 7'd0);
		send_request(CMD_INSERT, 32'sd11, 7'd63);
		send_request(CMD_PUSH_FRONT, 32'sd12, 7'd0);
		wait_until_drained();
		// drain to empty, then knock on the empty store
		sender_gaps_on = 1'b0;
		while (deque_image.size() > 0)
			send_request(CMD_W'($urandom_range(CMD_POP_FRONT, CMD_POP_BACK)), pick_value(),
				pick_position());
		send_request(CMD_POP_FRONT, 32'sd0, 7'd0);
		send_request(CMD_POP_BACK, 32'sd0, 7'd0);
		sender_gaps_on = 1'b1;
		send_request(CMD_POP_BACK, 32'sd0, 7'd0);
		wait_until_drained();
	endtask

	task automatic test_random_mix(int n_items);
		int push_pct;
		int roll;
		logic [CMD_W-1:0] cmd;
		push_pct = 50;
		for (int i = 0; i < n_items; i++) begin
			// every 40 requests pick a new fill tendency and gap mode so the count wanders
			if (i % 40 == 0) begin
				push_pct = $urandom_range(15, 85);
				sender_gaps_on = ($urandom_range(0, 3) != 0);
			end
			if (i % 150 == 149)
				wait_until_drained();
			roll = $urandom_range(0, 99);
			if (roll < 3)
				cmd = CMD_W'($urandom_range(CMD_SPARE_5, CMD_SPARE_7));
			else if ($urandom_range(0, 99) < push_pct)
				cmd = CMD_W'($urandom_range(CMD_PUSH_FRONT, CMD_INSERT));
			else
				cmd = CMD_W'($urandom_range(CMD_POP_FRONT, CMD_POP_BACK));
			send_request(cmd, pick_value(), pick_position());
		end
		wait_until_drained();
	endtask

	initial begin
		// reset held from time zero, released on a falling edge
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_full_store();
		test_random_mix(440);

		stop_sending();
		while (pending_snapshots.size() != 0) @(negedge clk);
		// give a stray late result a chance to show up
		repeat (TAIL_CYCLES) @(posedge clk);
		@(negedge clk);
		if (pending_snapshots.size() != 0)
			report_mismatch("results never arrived", pending_snapshots.size(), '0);

		if (error_count == 0)
			$display("[bounded_deque_with_insert_core] OK");
		else
			$display("[bounded_deque_with_insert_core] ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/bdq_pkg.sv
rtl/core/bdq_ctrl.sv
rtl/core/bdq_cells.sv
rtl/core/bounded_deque_with_insert_core.sv
tb/bounded_deque_with_insert_core_tb.sv
